>>> hdl/gf256_alu_with_aes_sbox_defines.svh
// assertion macros shared by the gf256 alu rtl
// expects signals clk and rst_n in the scope of each use
`ifndef GF256_ALU_WITH_AES_SBOX_DEFINES_SVH
`define GF256_ALU_WITH_AES_SBOX_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define GFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/gfa_pkg.sv
// types, constants and field helpers for the gf256 alu
// no dependencies
package gfa_pkg;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_MUL  = 2'd1,
    CMD_INV  = 2'd2,
    CMD_SBOX = 2'd3
  } cmd_t;

  localparam logic [7:0] GF_REDUCE    = 8'h1B;
  localparam logic [7:0] AFFINE_CONST = 8'h63;
  localparam logic [7:0] GF_ORDER     = 8'hFF;
  localparam logic [7:0] GF_GEN       = 8'h03;
  localparam int         TBL_DEPTH    = 256;

  // multiply by x, reduced by the aes polynomial
  function automatic logic [7:0] gf_xtime(input logic [7:0] v);
    gf_xtime = {v[6:0], 1'b0} ^ (v[7] ? GF_REDUCE : 8'h00);
  endfunction

  // shift-and-add multiply, eight narrow steps
  function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] acc;
    logic [7:0] xs;
    acc = 8'h00;
    xs  = x;
    for (int i = 0; i < 8; i++) begin
      if (y[i]) begin
        acc = acc ^ xs;
      end
      xs = gf_xtime(xs);
    end
    gf_mul = acc;
  endfunction

  // aes affine map
  function automatic logic [7:0] aes_affine(input logic [7:0] v);
    aes_affine = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]}
               ^ {v[3:0], v[7:4]} ^ AFFINE_CONST;
  endfunction

endpackage

>>> hdl/gfa_ifs.sv
// valid/ready channel interfaces for the gf256 alu
// uses gfa_pkg for the operation code type
interface gfa_req_if;
  logic          valid;
  logic          ready;
  gfa_pkg::cmd_t cmd;
  logic [7:0]    operand_a;
  logic [7:0]    operand_b;

  modport source (output valid, cmd, operand_a, operand_b, input ready);
  modport sink   (input valid, cmd, operand_a, operand_b, output ready);
endinterface

interface gfa_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_byte;

  modport source (output valid, result_byte, input ready);
  modport sink   (input valid, result_byte, output ready);
endinterface

>>> hdl/gf256_alu_with_aes_sbox.sv
// GF(2^8) alu (poly 0x11B): add, multiply, inverse and aes s-box, one byte per request.
// After reset the unit builds its log and exp tables in two 256x8 rams by walking powers of
// the generator 3, with in ready held low meanwhile. From then on it takes one request per
// clock unless the output stalls; stages: log ram read, exp ram read, output register.
// Inverse is exp[(255 - log[a]) mod 255] and 0 maps to 0; the s-box applies the affine map.
// Uses gfa_pkg, gfa_ifs and gfa_ram.
`include "gf256_alu_with_aes_sbox_defines.svh"

module gf256_alu_with_aes_sbox (
  input logic     clk,
  input logic     rst_n,
  gfa_req_if.sink   in_chan,
  gfa_rsp_if.source out_chan
);

  // table fill
  logic       fill_busy_r, fill_busy_nxt;
  logic [7:0] fill_cnt_r, fill_cnt_nxt;
  logic [7:0] fill_g_r, fill_g_nxt;

  // pipeline
  logic          advance;
  logic          in_fire;
  logic          v1_r, v2_r, out_valid_r;
  gfa_pkg::cmd_t cmd1_r, cmd2_r;
  logic [7:0]    a1_r, b1_r;
  logic          zero2_r;
  logic [7:0]    arith2_r;
  logic [7:0]    result_r, result_nxt;
  logic [7:0]    log_rdata, exp_rdata, exp_idx, arith1, inv2;

  assign advance = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !fill_busy_r && advance;
  assign in_fire = in_chan.valid && in_chan.ready;

  always_comb begin
    fill_busy_nxt = fill_busy_r;
    fill_cnt_nxt  = fill_cnt_r;
    fill_g_nxt    = fill_g_r;
    if (fill_busy_r) begin
      fill_cnt_nxt = fill_cnt_r + 8'd1;
      fill_g_nxt   = gfa_pkg::gf_mul(fill_g_r, gfa_pkg::GF_GEN);
      if (fill_cnt_r == gfa_pkg::GF_ORDER - 8'd1) begin
        fill_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_busy_r <= 1'b1;
      fill_cnt_r  <= 8'd0;
      fill_g_r    <= 8'd1;
    end else begin
      fill_busy_r <= fill_busy_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      fill_g_r    <= fill_g_nxt;
    end
  end

  // log[g] = i
  gfa_ram #(.WIDTH(8), .DEPTH(gfa_pkg::TBL_DEPTH)) u_log_ram (
    .clk   (clk),
    .we    (fill_busy_r),
    .waddr (fill_g_r),
    .wdata (fill_cnt_r),
    .re    (advance),
    .raddr (in_chan.operand_a),
    .rdata (log_rdata)
  );

  // exp[i] = g
  gfa_ram #(.WIDTH(8), .DEPTH(gfa_pkg::TBL_DEPTH)) u_exp_ram (
    .clk   (clk),
    .we    (fill_busy_r),
    .waddr (fill_cnt_r),
    .wdata (fill_g_r),
    .re    (advance),
    .raddr (exp_idx),
    .rdata (exp_rdata)
  );

  // (255 - log) mod 255
  assign exp_idx = (log_rdata == 8'd0) ? 8'd0 : gfa_pkg::GF_ORDER - log_rdata;
  assign arith1  = (cmd1_r == gfa_pkg::CMD_ADD) ? (a1_r ^ b1_r)
                                                : gfa_pkg::gf_mul(a1_r, b1_r);
  assign inv2    = zero2_r ? 8'd0 : exp_rdata;

  always_comb begin
    unique case (cmd2_r)
      gfa_pkg::CMD_ADD, gfa_pkg::CMD_MUL: result_nxt = arith2_r;
      gfa_pkg::CMD_INV:                   result_nxt = inv2;
      gfa_pkg::CMD_SBOX:                  result_nxt = gfa_pkg::aes_affine(inv2);
      default:                            result_nxt = arith2_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      v1_r        <= in_fire;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cmd1_r   <= in_chan.cmd;
      a1_r     <= in_chan.operand_a;
      b1_r     <= in_chan.operand_b;
      cmd2_r   <= cmd1_r;
      zero2_r  <= (a1_r == 8'd0);
      arith2_r <= arith1;
      result_r <= result_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.result_byte = result_r;

  `GFA_ASSERT_NOW(a_fill_quiet, fill_busy_r, !v1_r && !v2_r && !out_valid_r, "request in flight during table fill")
  `GFA_ASSERT_NOW(a_gen_wraps, $fell(fill_busy_r), fill_g_r == 8'd1, "generator powers did not wrap to one after fill")
  `GFA_ASSERT_NEXT(a_req_enters, in_fire, v1_r, "accepted request missing from first stage")
  `GFA_ASSERT_NEXT(a_stage_moves, v1_r && advance, v2_r, "request lost between table reads")

endmodule

>>> hdl/gfa_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module gfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
